### hdl/wsfr_pkg.sv
package wsfr_pkg;

  // Opcodes taken from the low nibble of the first header byte
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_UNKNOWN = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_e;

  typedef struct packed {
    logic       is_text;
    kind_e      kind;
    logic       last;
    logic [7:0] data_byte;
  } result_t;

endpackage

### hdl/wsfr_parser.sv
module wsfr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,       // consume rx_byte_i this cycle
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output wsfr_pkg::result_t    res_o
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;

  logic        is_data_op;
  logic        is_known_op;
  logic [63:0] len_val;
  logic        len_done;
  logic        end_frame;
  logic [7:0]  key_byte;
  logic        data_last;

  assign is_data_op  = (opcode_q == wsfr_pkg::OP_TEXT) || (opcode_q == wsfr_pkg::OP_BINARY);
  assign is_known_op = is_data_op || (opcode_q == wsfr_pkg::OP_CLOSE) ||
                       (opcode_q == wsfr_pkg::OP_PONG);
  assign data_last   = (rem_q == 64'd1);

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    kidx_d    = kidx_q;
    len_val   = rem_q;
    len_done  = 1'b0;
    end_frame = 1'b0;
    res_valid_o         = 1'b0;
    res_o.kind          = wsfr_pkg::KIND_DATA;
    res_o.data_byte     = 8'd0;
    res_o.is_text       = 1'b0;
    res_o.last          = 1'b0;

    if (en_i) begin
      case (phase_q)
        PH_HDR1: begin
          if (!is_known_op) begin
            phase_d     = PH_HDR0;
            res_valid_o = 1'b1;
            res_o.kind  = wsfr_pkg::KIND_UNKNOWN;
          end else begin
            masked_d = rx_byte_i[7];
            rem_d    = 64'd0;
            if (rx_byte_i[6:0] == wsfr_pkg::LEN_EXT16) begin
              phase_d = PH_EXTLEN;
              cnt_d   = 3'd1;
            end else if (rx_byte_i[6:0] == wsfr_pkg::LEN_EXT64) begin
              phase_d = PH_EXTLEN;
              cnt_d   = 3'd7;
            end else begin
              len_val  = {57'd0, rx_byte_i[6:0]};
              rem_d    = len_val;
              len_done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          len_val = {rem_q[55:0], rx_byte_i};
          rem_d   = len_val;
          if (cnt_q != 3'd0) begin
            cnt_d = cnt_q - 3'd1;
          end else begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (cnt_q != 3'd0) begin
            cnt_d = cnt_q - 3'd1;
          end else if (rem_q != 64'd0) begin
            phase_d = PH_DATA;
          end else begin
            end_frame = 1'b1;
          end
        end
        PH_DATA: begin
          kidx_d = kidx_q + 2'd1;
          rem_d  = rem_q - 64'd1;
          if (is_data_op) begin
            if (data_last) begin
              phase_d = PH_HDR0;
            end
            res_valid_o     = 1'b1;
            res_o.kind      = wsfr_pkg::KIND_DATA;
            res_o.data_byte = masked_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
            res_o.is_text   = (opcode_q == wsfr_pkg::OP_TEXT);
            res_o.last      = data_last;
          end else if (data_last) begin
            end_frame = 1'b1;
          end
        end
        default: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
      endcase

      // length known: key next, then payload, else the frame is empty
      if (len_done) begin
        kidx_d = 2'd0;
        if (masked_d) begin
          phase_d = PH_KEY;
          cnt_d   = 3'd3;
        end else if (len_val != 64'd0) begin
          phase_d = PH_DATA;
        end else begin
          end_frame = 1'b1;
        end
      end

      if (end_frame) begin
        phase_d = PH_HDR0;
        if (opcode_q == wsfr_pkg::OP_CLOSE) begin
          res_valid_o = 1'b1;
          res_o.kind  = wsfr_pkg::KIND_CLOSE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= 4'd0;
      masked_q <= 1'b0;
      rem_q    <= 64'd0;
      cnt_q    <= 3'd0;
      key_q    <= 32'd0;
      kidx_q   <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

### hdl/websocket_frame_receiver.sv
// WebSocket frame receiver: takes the received byte stream one byte per transfer and
// parses frames (opcode, mask bit, 7-bit, 16-bit or 64-bit length, masking key).
// Text and binary payload bytes come out unmasked, one per transfer, with tlast on
// the final byte of the frame; empty data frames produce nothing. Close and pong
// payloads are dropped, a close frame gives one close event when fully consumed, and
// any other opcode gives an unknown-opcode event after its two header bytes. The
// block accepts one byte every clock cycle while the output is not backpressured:
// each byte goes through an input register, a parser state update, and an output
// register, and throughput is limited only by output backpressure.
module websocket_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] is_text
  output logic       m_axis_tlast    // last
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  wsfr_pkg::result_t out_q;
  logic              advance;
  logic              res_valid;
  wsfr_pkg::result_t res;

  // stage moves when the output slot is free or being emptied
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  wsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_valid_q && advance),
    .rx_byte_i   (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_valid_q && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data_byte;
  assign m_axis_tuser  = {out_q.is_text, out_q.kind};
  assign m_axis_tlast  = out_q.last;

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HDR0,
    ST_HDR1,
    ST_EXTLEN,
    ST_KEY,
    ST_DATA
  } parse_state_e;

  localparam int LEN_SHORT = 0;
  localparam int LEN_MID   = 1;
  localparam int LEN_LONG  = 2;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] data_byte
  logic [2:0] m_axis_tuser;           // [1:0] kind, [2] is_text
  logic       m_axis_tlast;

  // frame parser mirror
  parse_state_e ps_state = ST_HDR0;
  logic [3:0]   ps_op = '0;
  logic         ps_masked = 1'b0;
  logic [63:0]  ps_remaining = '0;
  logic [2:0]   ps_hdr_cnt = '0;
  logic [31:0]  ps_key = '0;
  logic [1:0]   ps_key_idx = '0;

  wsfr_pkg::result_t pending_results[$];
  int      n_errors = 0;
  int      n_bytes_sent = 0;
  int      src_gap_pct = 0;
  int      sink_stall_pct = 0;
  longint  sink_cycle = 0;
  longint  hold_end = 0;

  websocket_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit is_known_op(input logic [3:0] op);
    return op == wsfr_pkg::OP_TEXT || op == wsfr_pkg::OP_BINARY ||
           op == wsfr_pkg::OP_CLOSE || op == wsfr_pkg::OP_PONG;
  endfunction

  task automatic frame_done(inout bit hit, inout wsfr_pkg::result_t r);
    ps_state = ST_HDR0;
    if (ps_op == wsfr_pkg::OP_CLOSE) begin
      hit = 1'b1;
      r.kind = wsfr_pkg::KIND_CLOSE;
    end
  endtask

  task automatic length_known(inout bit hit, inout wsfr_pkg::result_t r);
    ps_key_idx = '0;
    if (ps_masked) begin
      ps_state = ST_KEY;
      ps_hdr_cnt = 3'd3;
    end else if (ps_remaining != 0) begin
      ps_state = ST_DATA;
    end else begin
      frame_done(hit, r);
    end
  endtask

  // Advance the parser mirror by one accepted byte; queue any result it yields.
  task automatic decode_byte(input logic [7:0] b);
    wsfr_pkg::result_t r;
    bit         hit;
    logic [7:0] d;
    bit         fin_byte;
    r = '0;
    hit = 1'b0;
    case (ps_state)
      ST_HDR1: begin
        if (!is_known_op(ps_op)) begin
          ps_state = ST_HDR0;
          hit = 1'b1;
          r.kind = wsfr_pkg::KIND_UNKNOWN;
        end else begin
          ps_masked = b[7];
          ps_remaining = '0;
          if (b[6:0] == wsfr_pkg::LEN_EXT16) begin
            ps_state = ST_EXTLEN;
            ps_hdr_cnt = 3'd1;
          end else if (b[6:0] == wsfr_pkg::LEN_EXT64) begin
            ps_state = ST_EXTLEN;
            ps_hdr_cnt = 3'd7;
          end else begin
            ps_remaining = {57'd0, b[6:0]};
            length_known(hit, r);
          end
        end
      end
      ST_EXTLEN: begin
        ps_remaining = {ps_remaining[55:0], b};
        if (ps_hdr_cnt != 0) ps_hdr_cnt = ps_hdr_cnt - 3'd1;
        else length_known(hit, r);
      end
      ST_KEY: begin
        ps_key = {ps_key[23:0], b};
        if (ps_hdr_cnt != 0) begin
          ps_hdr_cnt = ps_hdr_cnt - 3'd1;
        end else if (ps_remaining != 0) begin
          ps_state = ST_DATA;
        end else begin
          frame_done(hit, r);
        end
      end
      ST_DATA: begin
        d = ps_masked ? b ^ ps_key[8 * (3 - int'(ps_key_idx)) +: 8] : b;
        ps_key_idx = ps_key_idx + 2'd1;
        ps_remaining = ps_remaining - 64'd1;
        fin_byte = (ps_remaining == 0);
        if (ps_op == wsfr_pkg::OP_TEXT || ps_op == wsfr_pkg::OP_BINARY) begin
          if (fin_byte) ps_state = ST_HDR0;
          hit = 1'b1;
          r.kind = wsfr_pkg::KIND_DATA;
          r.data_byte = d;
          r.is_text = (ps_op == wsfr_pkg::OP_TEXT);
          r.last = fin_byte;
        end else if (fin_byte) begin
          frame_done(hit, r);
        end
      end
      default: begin
        ps_op = b[3:0];
        ps_state = ST_HDR1;
      end
    endcase
    if (hit) pending_results = {pending_results, r};
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b);
    n_bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input bit msk, input int len_kind,
                            input logic [63:0] len);
    send_byte({4'($urandom), op});
    if (!is_known_op(op)) begin
      // only the two header bytes belong to this frame
      send_byte(8'($urandom));
      return;
    end
    case (len_kind)
      LEN_SHORT: send_byte({msk, len[6:0]});
      LEN_MID: begin
        send_byte({msk, wsfr_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({msk, wsfr_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (msk) repeat (4) send_byte(8'($urandom));
    for (longint i = 0; i < longint'(len); i++) send_byte(8'($urandom));
  endtask

  // Random byte that keeps any extended length it lands in below 256.
  function automatic logic [7:0] stray_byte();
    if (ps_state == ST_EXTLEN && ps_hdr_cnt != 0) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic random_frame();
    int          pick;
    logic [3:0]  op;
    int          form;
    logic [63:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // broken stream: stray bytes, then bytes until the parser is back at a header
      repeat ($urandom_range(1, 4)) send_byte(stray_byte());
      while (ps_state != ST_HDR0) send_byte(stray_byte());
      return;
    end
    if (pick < 40) op = wsfr_pkg::OP_TEXT;
    else if (pick < 70) op = wsfr_pkg::OP_BINARY;
    else if (pick < 81) op = wsfr_pkg::OP_CLOSE;
    else if (pick < 91) op = wsfr_pkg::OP_PONG;
    else begin
      op = 4'($urandom);
      while (is_known_op(op)) op = 4'($urandom);
    end
    pick = $urandom_range(0, 99);
    form = LEN_SHORT;
    if (pick < 75) begin
      len = 64'($urandom_range(0, 12));
    end else if (pick < 85) begin
      len = 64'($urandom_range(0, 125));
    end else if (pick < 93) begin
      form = LEN_MID;
      len = 64'($urandom_range(0, 40));
    end else if (pick < 96) begin
      form = LEN_MID;
      len = 64'($urandom_range(126, 200));
    end else begin
      form = LEN_LONG;
      len = 64'($urandom_range(0, 30));
    end
    send_frame(op, 1'($urandom), form, len);
  endtask

  task automatic run_directed_frames();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    // one-byte text frame, unmasked
    send_byte(8'h81); send_byte(8'h01); send_byte(8'h41);
    // masked binary frame, two bytes
    send_byte(8'h82); send_byte(8'h82);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h5A); send_byte(8'hA5);
    send_byte(8'h00); send_byte(8'hFF);
    // empty text frame gives nothing
    send_byte(8'h01); send_byte(8'h00);
    // empty close frame reports on its second header byte
    send_byte(8'h88); send_byte(8'h00);
    // ping is unknown: only the header is eaten
    send_byte(8'hF9); send_byte(8'hFF);
    // 16-bit length smaller than 126
    send_byte(8'h02); send_byte(8'h7E); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'hFF);
    // close with one payload byte
    send_byte(8'h78); send_byte(8'h01); send_byte(8'h55);
  endtask

  task automatic run_random_frames(input int gap_pct, input int stall_pct, input int n_items);
    int stop_at;
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    stop_at = n_bytes_sent + n_items;
    while (n_bytes_sent < stop_at) random_frame();
  endtask

  task automatic run_output_hold();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_end = sink_cycle + 200;
    send_frame(wsfr_pkg::OP_TEXT, 1'b1, LEN_MID, 64'd160);
  endtask

  // length with bit 63 set: the frame never ends, so this goes last
  task automatic run_oversized_length();
    src_gap_pct = 20;
    sink_stall_pct = 20;
    send_byte(8'h81);
    send_byte({1'b1, wsfr_pkg::LEN_EXT64});
    send_byte(8'h80 | 8'($urandom));
    repeat (7) send_byte(8'($urandom));
    repeat (4) send_byte(8'($urandom));
    repeat (24) send_byte(8'($urandom));
  endtask

  always @(negedge clk_i) begin
    sink_cycle++;
    if (sink_cycle < hold_end) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    wsfr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: kind=%0d data_byte=%h", m_axis_tuser[1:0], m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[1:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser[1:0]);
          n_errors++;
        end
        if (m_axis_tdata !== want.data_byte) begin
          $error("data_byte: expected %h, got %h", want.data_byte, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tuser[2] !== want.is_text) begin
          $error("is_text: expected %0d, got %0d", want.is_text, m_axis_tuser[2]);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed_frames();
    run_random_frames(0, 0, 230);
    run_random_frames(53, 0, 230);
    run_random_frames(0, 53, 230);
    run_output_hold();
    run_random_frames(9, 9, 230);
    run_oversized_length();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
